FILE: rtl/core/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg
// shared widths, codes and control types of the positional ordered list
// ----------------------------------------------------------------------------
`default_nettype none

package pol_pkg;

    parameter int unsigned POL_CAPACITY   = 16;
    parameter int unsigned POL_DESC_CHARS = 8;

    localparam int unsigned MODE_W   = 2;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned PRICE_W  = 32;
    localparam int unsigned DESC_W   = 64;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LEN_W    = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_GET    = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [POS_W-1:0] pos;
    } t_shift_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/positional_ordered_list.sv
// ----------------------------------------------------------------------------
// positional_ordered_list
// ordered list of price and description entries held in a chain of cells
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  request   in         i_valid / o_ready   i_mode, i_position, i_new_price,
//                                           i_new_description
//  result    out        o_valid / i_ready   o_status, o_read_price,
//                                           o_read_description, o_list_length
//
//  one request per cycle barring stalls; result is registered on acceptance
//  insert/remove shift cells from the position on by one slot in parallel
//  get reads the addressed cell through one mux in the accepting cycle
//  reset clears the entry count and the result valid; cells are not cleared
//  a new request is taken while a result waits only if that result leaves
// ----------------------------------------------------------------------------
`default_nettype none

module positional_ordered_list
    import pol_pkg::*;
#(
    parameter int unsigned CAPACITY   = POL_CAPACITY,
    parameter int unsigned DESC_CHARS = POL_DESC_CHARS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [MODE_W-1:0]          i_mode,
    input  wire logic [POS_W-1:0]           i_position,
    input  wire logic signed [PRICE_W-1:0]  i_new_price,
    input  wire logic [DESC_W-1:0]          i_new_description,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [STATUS_W-1:0]             o_status,
    output logic signed [PRICE_W-1:0]       o_read_price,
    output logic [DESC_W-1:0]               o_read_description,
    output logic [LEN_W-1:0]                o_list_length
);

    localparam int unsigned CW  = $clog2(CAPACITY + 1);
    localparam int unsigned DW  = DESC_CHARS * 8;
    localparam int unsigned NR  = (CAPACITY < 32) ? CAPACITY : 32;
    localparam int unsigned IW  = $clog2(NR);
    localparam logic [31:0] LP_CAP = 32'(CAPACITY);

    logic signed [PRICE_W-1:0] w_price     [CAPACITY];
    logic [DW-1:0]             w_desc      [CAPACITY];
    logic signed [PRICE_W-1:0] w_rd_price  [NR];
    logic [DW-1:0]             w_rd_desc   [NR];
    logic [DW-1:0]             w_new_desc;

    logic [CW-1:0]             r_count, n_count;
    logic                      r_valid;
    t_status                   r_status, n_status;
    logic signed [PRICE_W-1:0] r_rd_price;
    logic [DESC_W-1:0]         r_rd_desc;
    logic [LEN_W-1:0]          r_len;

    logic                      w_acc;
    logic                      w_rd_ok;
    t_mode                     w_mode;
    t_shift_ctl                w_ctl;
    logic [31:0]               w_pos;
    logic [31:0]               w_cnt;
    logic [IW-1:0]             w_idx;

    assign w_new_desc = i_new_description[DW-1:0];

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [PRICE_W-1:0] w_lp, w_rp;
        logic [DW-1:0]             w_ld, w_rd;

        if (g == 0) begin : g_first
            assign w_lp = i_new_price;
            assign w_ld = w_new_desc;
        end else begin : g_mid_l
            assign w_lp = w_price[g-1];
            assign w_ld = w_desc[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_rp = '0;
            assign w_rd = '0;
        end else begin : g_mid_r
            assign w_rp = w_price[g+1];
            assign w_rd = w_desc[g+1];
        end

        pol_cell #(
            .IDX        (g),
            .DESC_W_INT (DW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_new_price   (i_new_price),
            .i_new_desc    (w_new_desc),
            .i_left_price  (w_lp),
            .i_left_desc   (w_ld),
            .i_right_price (w_rp),
            .i_right_desc  (w_rd),
            .o_price       (w_price[g]),
            .o_desc        (w_desc[g])
        );
    end

    // only the first cells are reachable by a position
    for (genvar j = 0; j < NR; j++) begin : g_rd
        assign w_rd_price[j] = w_price[j];
        assign w_rd_desc[j]  = w_desc[j];
    end

    assign w_idx   = i_position[IW-1:0];
    assign o_ready = !r_valid || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign w_mode  = t_mode'(i_mode);
    assign w_pos   = 32'(i_position);
    assign w_cnt   = 32'(r_count);

    always_comb begin
        n_count   = r_count;
        n_status  = ST_OK;
        w_rd_ok   = 1'b0;
        w_ctl.ins = 1'b0;
        w_ctl.rem = 1'b0;
        w_ctl.pos = i_position;
        unique case (w_mode)
            MODE_GET: begin
                if (w_pos >= w_cnt) begin
                    n_status = ST_BAD_POS;
                end else begin
                    w_rd_ok = 1'b1;
                end
            end
            MODE_INSERT: begin
                if (w_pos > w_cnt) begin
                    n_status = ST_BAD_POS;
                end else if (w_cnt == LP_CAP) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.ins = w_acc;
                    n_count   = r_count + CW'(1);
                end
            end
            MODE_REMOVE: begin
                if (w_pos >= w_cnt) begin
                    n_status = ST_BAD_POS;
                end else begin
                    w_ctl.rem = w_acc;
                    n_count   = r_count - CW'(1);
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status   <= n_status;
            r_rd_price <= w_rd_ok ? w_rd_price[w_idx] : '0;
            r_rd_desc  <= w_rd_ok ? DESC_W'(w_rd_desc[w_idx]) : '0;
            r_len      <= LEN_W'(n_count);
        end
    end

    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_read_price       = r_rd_price;
    assign o_read_description = r_rd_desc;
    assign o_list_length      = r_len;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= LP_CAP)
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.ins) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list by one");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.rem) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not shrink the list by one");

    a_full_only_at_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (32'(r_count) == LP_CAP))
        else $error("full status while list not full");

    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> ((o_read_price == '0) &&
                                              (o_read_description == '0)))
        else $error("read fields nonzero on failed request");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_mode == MODE_CLEAR)) |=> (r_count == '0))
        else $error("clear left entries");

endmodule

`default_nettype wire

FILE: rtl/core/pol_cell.sv
// ----------------------------------------------------------------------------
// pol_cell
// one list slot: holds, loads a new entry or takes a neighbor's entry
// ----------------------------------------------------------------------------
`default_nettype none

module pol_cell
    import pol_pkg::*;
#(
    parameter int unsigned IDX    = 0,
    parameter int unsigned DESC_W_INT = 64
) (
    input  wire logic                         i_clk,
    input  wire t_shift_ctl                   i_ctl,
    input  wire logic signed [PRICE_W-1:0]    i_new_price,
    input  wire logic [DESC_W_INT-1:0]        i_new_desc,
    input  wire logic signed [PRICE_W-1:0]    i_left_price,
    input  wire logic [DESC_W_INT-1:0]        i_left_desc,
    input  wire logic signed [PRICE_W-1:0]    i_right_price,
    input  wire logic [DESC_W_INT-1:0]        i_right_desc,
    output logic signed [PRICE_W-1:0]         o_price,
    output logic [DESC_W_INT-1:0]             o_desc
);

    localparam logic [31:0] LP_IDX = 32'(IDX);

    logic signed [PRICE_W-1:0] r_price, n_price;
    logic [DESC_W_INT-1:0]     r_desc, n_desc;
    logic [31:0]               w_pos;

    assign w_pos = 32'(i_ctl.pos);

    always_comb begin
        n_price = r_price;
        n_desc  = r_desc;
        priority if (i_ctl.ins && (LP_IDX == w_pos)) begin
            n_price = i_new_price;
            n_desc  = i_new_desc;
        end else if (i_ctl.ins && (LP_IDX > w_pos)) begin
            n_price = i_left_price;
            n_desc  = i_left_desc;
        end else if (i_ctl.rem && (LP_IDX >= w_pos)) begin
            n_price = i_right_price;
            n_desc  = i_right_desc;
        end else begin
            n_price = r_price;
            n_desc  = r_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_price <= n_price;
        r_desc  <= n_desc;
    end

    assign o_price = r_price;
    assign o_desc  = r_desc;

endmodule

`default_nettype wire

FILE: dv/pol_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_checker
// watches both channels of the positional ordered list, keeps its own copy of
// the held entries, predicts one result per accepted request and compares
// every accepted result field by field with the oldest prediction
// ----------------------------------------------------------------------------
module pol_checker
    import pol_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_req_valid,
    input  wire logic                      i_req_ready,
    input  wire logic [MODE_W-1:0]         i_mode,
    input  wire logic [POS_W-1:0]          i_position,
    input  wire logic signed [PRICE_W-1:0] i_new_price,
    input  wire logic [DESC_W-1:0]         i_new_description,
    input  wire logic                      i_res_valid,
    input  wire logic                      i_res_ready,
    input  wire logic [STATUS_W-1:0]       i_status,
    input  wire logic signed [PRICE_W-1:0] i_read_price,
    input  wire logic [DESC_W-1:0]         i_read_description,
    input  wire logic [LEN_W-1:0]          i_list_length,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_held
);

    typedef struct packed {
        t_status                   status;
        logic signed [PRICE_W-1:0] price;
        logic [DESC_W-1:0]         desc;
        logic [LEN_W-1:0]          len;
    } t_list_result;

    localparam logic [DESC_W-1:0] DESC_MASK = (POL_DESC_CHARS >= 8) ? '1 :
        ((64'd1 << (POL_DESC_CHARS * 8)) - 64'd1);

    logic signed [PRICE_W-1:0] shelf_price [POL_CAPACITY];
    logic [DESC_W-1:0]         shelf_desc  [POL_CAPACITY];
    int unsigned               held;
    t_list_result              expected_results [$];
    t_list_result              want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_held       = 0;
        held         = 0;
    end

    function automatic t_list_result apply_request(t_mode m, logic [POS_W-1:0] pos,
                                                   logic signed [PRICE_W-1:0] price,
                                                   logic [DESC_W-1:0] desc);
        t_list_result r;
        int           i;
        r        = '0;
        r.status = ST_OK;
        case (m)
            MODE_GET: begin
                if (pos >= held || pos >= POL_CAPACITY) begin
                    r.status = ST_BAD_POS;
                end else begin
                    r.price = shelf_price[pos];
                    r.desc  = shelf_desc[pos];
                end
            end
            MODE_INSERT: begin
                if (pos > held) begin
                    r.status = ST_BAD_POS;
                end else if (held >= POL_CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = held; i > pos; i--) begin
                        shelf_price[i] = shelf_price[i-1];
                        shelf_desc[i]  = shelf_desc[i-1];
                    end
                    shelf_price[pos] = price;
                    shelf_desc[pos]  = desc & DESC_MASK;
                    held++;
                end
            end
            MODE_REMOVE: begin
                if (pos >= held || pos >= POL_CAPACITY) begin
                    r.status = ST_BAD_POS;
                end else begin
                    for (i = pos; i + 1 < held; i++) begin
                        shelf_price[i] = shelf_price[i+1];
                        shelf_desc[i]  = shelf_desc[i+1];
                    end
                    held--;
                end
            end
            default: begin
                held = 0;
            end
        endcase
        r.len = held[LEN_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] exp_val, logic [63:0] got_val);
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, exp_val, got_val);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held = 0;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unrequested result", '0, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", want.status, i_status);
                    if (i_read_price !== want.price)
                        report_mismatch("read_price", want.price, i_read_price);
                    if (i_read_description !== want.desc)
                        report_mismatch("read_description", want.desc, i_read_description);
                    if (i_list_length !== want.len)
                        report_mismatch("list_length", want.len, i_list_length);
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_results.push_back(apply_request(t_mode'(i_mode), i_position,
                                                         i_new_price, i_new_description));
            end
        end
        o_pending = expected_results.size();
        o_held    = held;
    end

endmodule

FILE: dv/tb_positional_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_ordered_list
// drives get, insert, remove and clear requests into the list with random
// gaps and result back-pressure; a checker beside the block predicts and
// compares every result, and this top gives the verdict
// ----------------------------------------------------------------------------
module tb_positional_ordered_list;
    import pol_pkg::*;

    localparam int ITEMS      = 1900;
    localparam int HOLD_LEN   = 64;
    localparam int IDLE_LIMIT = 2000;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      req_valid;
    logic                      req_ready;
    logic [MODE_W-1:0]         mode;
    logic [POS_W-1:0]          position;
    logic signed [PRICE_W-1:0] new_price;
    logic [DESC_W-1:0]         new_description;
    logic                      res_valid;
    logic                      res_ready;
    logic [STATUS_W-1:0]       status;
    logic signed [PRICE_W-1:0] read_price;
    logic [DESC_W-1:0]         read_description;
    logic [LEN_W-1:0]          list_length;

    int fail_count;
    int pending;
    int list_held;
    int idle_cycles = 0;
    bit steady      = 1'b0;
    bit hold_results = 1'b0;

    always #4 clk = ~clk;

    positional_ordered_list dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_valid            (req_valid),
        .o_ready            (req_ready),
        .i_mode             (mode),
        .i_position         (position),
        .i_new_price        (new_price),
        .i_new_description  (new_description),
        .o_valid            (res_valid),
        .i_ready            (res_ready),
        .o_status           (status),
        .o_read_price       (read_price),
        .o_read_description (read_description),
        .o_list_length      (list_length)
    );

    pol_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_req_valid        (req_valid),
        .i_req_ready        (req_ready),
        .i_mode             (mode),
        .i_position         (position),
        .i_new_price        (new_price),
        .i_new_description  (new_description),
        .i_res_valid        (res_valid),
        .i_res_ready        (res_ready),
        .i_status           (status),
        .i_read_price       (read_price),
        .i_read_description (read_description),
        .i_list_length      (list_length),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_held             (list_held)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(t_mode m, logic [POS_W-1:0] pos,
                                logic signed [PRICE_W-1:0] price, logic [DESC_W-1:0] desc);
        int g;
        g = steady ? 0 : pick_gap();
        if (g > 0) begin
            req_valid = 1'b0;
            repeat (g) @(negedge clk);
        end
        req_valid       = 1'b1;
        mode            = m;
        position        = pos;
        new_price       = price;
        new_description = desc;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // result side back-pressure
    initial begin
        int g;
        res_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_results) begin
                hold_results = 1'b0;
                g = HOLD_LEN;
            end else begin
                g = steady ? 0 : pick_gap();
            end
            if (g > 0) begin
                res_ready = 1'b0;
                repeat (g) @(negedge clk);
            end
            res_ready = 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int               n;
        int               r;
        int               ins_cut;
        int               rem_cut;
        t_mode            m;
        logic [POS_W-1:0] p;

        rst_n           = 1'b0;
        req_valid       = 1'b0;
        mode            = MODE_GET;
        position        = '0;
        new_price       = '0;
        new_description = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // empty list corner cases
        send_request(MODE_GET,    5'd0, 32'sd0, 64'd0);
        send_request(MODE_REMOVE, 5'd0, 32'sd0, 64'd0);
        send_request(MODE_INSERT, 5'd1, 32'sd5, 64'd5);
        // price and description extremes
        send_request(MODE_INSERT, 5'd0, 32'sh8000_0000, 64'hffff_ffff_ffff_ffff);
        send_request(MODE_INSERT, 5'd1, 32'sh7fff_ffff, 64'd0);
        send_request(MODE_INSERT, 5'd0, -32'sd1, 64'h0123_4567_89ab_cdef);
        send_request(MODE_INSERT, 5'd3, 32'sd0, 64'h4142_4344_4546_4748);
        send_request(MODE_GET,    5'd0, 32'sd0, 64'd0);
        send_request(MODE_GET,    5'd3, 32'sd0, 64'd0);
        send_request(MODE_GET,    5'd4, 32'sd0, 64'd0);
        send_request(MODE_REMOVE, 5'd1, 32'sd0, 64'd0);
        send_request(MODE_GET,    5'd1, 32'sd0, 64'd0);
        send_request(MODE_CLEAR,  5'd7, 32'sd0, 64'd0);
        send_request(MODE_GET,    5'd0, 32'sd0, 64'd0);
        // fill to capacity, then full and last-slot cases
        for (n = 0; n < POL_CAPACITY; n++)
            send_request(MODE_INSERT, POS_W'($urandom_range(0, n)), $urandom,
                         {$urandom, $urandom});
        send_request(MODE_INSERT, 5'd16, 32'sd1, 64'd1);
        send_request(MODE_INSERT, 5'd0,  32'sd1, 64'd1);
        send_request(MODE_GET,    5'd15, 32'sd0, 64'd0);
        send_request(MODE_GET,    5'd16, 32'sd0, 64'd0);
        send_request(MODE_REMOVE, 5'd16, 32'sd0, 64'd0);
        send_request(MODE_REMOVE, 5'd15, 32'sd0, 64'd0);
        send_request(MODE_REMOVE, 5'd0,  32'sd0, 64'd0);

        for (n = 0; n < ITEMS; n++) begin
            if (n == 600) hold_results = 1'b1;
            steady = (n >= 600 && n < 640) || (n >= 1200 && n < 1350);
            if (n == 1000 || n == 1500) wait_drained();

            // alternate between growing and shrinking the list
            if (((n / 150) % 2) == 0) begin
                ins_cut = 55;
                rem_cut = 70;
            end else begin
                ins_cut = 30;
                rem_cut = 65;
            end
            r = $urandom_range(0, 99);
            if (r < 2)
                m = MODE_CLEAR;
            else if (r < ins_cut)
                m = MODE_INSERT;
            else if (r < rem_cut)
                m = MODE_REMOVE;
            else
                m = MODE_GET;

            if ($urandom_range(0, 9) == 0)
                p = POS_W'($urandom_range(0, POL_CAPACITY));
            else if (m == MODE_INSERT)
                p = POS_W'($urandom_range(0, list_held));
            else if (list_held == 0)
                p = '0;
            else
                p = POS_W'($urandom_range(0, list_held - 1));

            send_request(m, p, $urandom, {$urandom, $urandom});
        end

        wait_drained();
        repeat (8) @(negedge clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
